// ===== rtl/zeck_pkg.sv =====
package zeck_pkg;

	// default and fixed sizes
	localparam int unsigned MAX_DIGITS_DEF   = 92;
	localparam int unsigned VALUE_W          = 64;
	localparam int unsigned RESULTS_PER_STEP = 64;
	localparam int unsigned STEP_W           = $clog2(RESULTS_PER_STEP);

	typedef logic [VALUE_W-1:0] value_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;   // take a new value, start weights at 1/1
		logic climb;  // advance to the next higher weight
		logic emit;   // produce one digit into the output register
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic climb_more;   // next weight still fits and digit budget allows it
		logic final_digit;  // digit produced now is the last one of the code
		logic out_free;     // output register can take a digit this cycle
	} dp_status_t;

	// controller states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CLIMB = 4'b0010,
		ST_EMIT  = 4'b0100,
		ST_PAUSE = 4'b1000
	} ctrl_state_t;

endpackage

// ===== rtl/zeck_if.sv =====
interface zeck_value_if;
	logic                valid;
	logic                ready;
	zeck_pkg::value_t    value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface zeck_digit_if;
	logic valid;
	logic ready;
	logic digit;
	logic last;

	modport source (output valid, output digit, output last, input ready);
	modport sink (input valid, input digit, input last, output ready);
endinterface

// ===== rtl/zeck_ctrl.sv =====
module zeck_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  zeck_pkg::dp_status_t status,
	output zeck_pkg::dp_cmd_t    cmd
);
	import zeck_pkg::*;

	ctrl_state_t       state_q, state_d;
	logic [STEP_W-1:0] step_cnt_q;
	logic              in_xfer;
	logic              step_full;

	assign in_ready  = (state_q == ST_IDLE) || (state_q == ST_PAUSE);
	assign in_xfer   = in_valid && in_ready;
	assign step_full = (step_cnt_q == STEP_W'(RESULTS_PER_STEP - 1));

	// command decode
	always_comb begin
		cmd       = '0;
		cmd.load  = in_xfer && (state_q == ST_IDLE);
		cmd.climb = (state_q == ST_CLIMB) && status.climb_more;
		cmd.emit  = (state_q == ST_EMIT) && status.out_free;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) state_d = ST_CLIMB;
			end
			ST_CLIMB: begin
				if (!status.climb_more) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					if (status.final_digit) state_d = ST_IDLE;
					else if (step_full) state_d = ST_PAUSE;
				end
			end
			ST_PAUSE: begin
				// a further input transfer resumes a long code; its value is unused
				if (in_xfer) state_d = ST_EMIT;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and per-transfer digit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_xfer) step_cnt_q <= '0;
			else if (cmd.emit) step_cnt_q <= step_cnt_q + STEP_W'(1);
		end
	end

endmodule

// ===== rtl/zeck_dp.sv =====
module zeck_dp #(
	parameter int unsigned MAX_DIGITS = zeck_pkg::MAX_DIGITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  zeck_pkg::dp_cmd_t    cmd,
	output zeck_pkg::dp_status_t status,
	input  zeck_pkg::value_t     value,
	output logic                 out_valid,
	output logic                 digit,
	output logic                 last,
	input  logic                 out_ready
);
	import zeck_pkg::*;

	localparam int unsigned DW = $clog2(MAX_DIGITS + 1);

	value_t           rem_q;
	value_t           wh_q;
	value_t           wl_q;
	logic [DW-1:0]    left_q;
	logic             out_valid_q;
	logic             digit_q;
	logic             last_q;

	logic [VALUE_W:0] sum;
	logic             fits;

	// weight compare logic
	assign sum  = {1'b0, wh_q} + {1'b0, wl_q};
	assign fits = (wh_q <= rem_q);

	assign status.climb_more  = (left_q < DW'(MAX_DIGITS)) && (sum <= {1'b0, rem_q});
	assign status.final_digit = (left_q == DW'(1));
	assign status.out_free    = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign digit     = digit_q;
	assign last      = last_q;

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// remainder, weight pair, digit count and output payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q  <= value;
			wh_q   <= VALUE_W'(1);
			wl_q   <= VALUE_W'(1);
			left_q <= DW'(1);
		end else if (cmd.climb) begin
			wh_q   <= sum[VALUE_W-1:0];
			wl_q   <= wh_q;
			left_q <= left_q + DW'(1);
		end else if (cmd.emit) begin
			if (fits) rem_q <= rem_q - wh_q;
			left_q  <= left_q - DW'(1);
			digit_q <= fits;
			last_q  <= status.final_digit;
			if (!status.final_digit) begin
				wh_q <= wl_q;
				wl_q <= wh_q - wl_q;
			end
		end
	end

endmodule

// ===== rtl/zeckendorf_encoder_unit.sv =====
// zeckendorf encoder: each code first climbs the weight ladder (one
// 64-bit add and compare per cycle), then moves one digit per cycle into the output
// register whenever it is free; a code above 64 digits needs a second input transfer,
// whose value is ignored, to release the remaining digits.
// reset: arst_n asynchronous, returns the controller to idle and empties the output.
module zeckendorf_encoder_unit #(
	parameter int unsigned MAX_DIGITS = zeck_pkg::MAX_DIGITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	zeck_value_if.sink   value_ch,
	zeck_digit_if.source digit_ch
);
	import zeck_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// sequencer
	zeck_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (value_ch.valid),
		.in_ready (value_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// remainder and weight datapath with output register
	zeck_dp #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.value     (value_ch.value),
		.out_valid (digit_ch.valid),
		.digit     (digit_ch.digit),
		.last      (digit_ch.last),
		.out_ready (digit_ch.ready)
	);

endmodule

// ===== tb/tb_zeckendorf_encoder_unit.sv =====
module tb_zeckendorf_encoder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ENC_MAX_DIGITS = zeck_pkg::MAX_DIGITS_DEF;
	localparam int unsigned DIGITS_PER_XFER = zeck_pkg::RESULTS_PER_STEP;
	localparam int unsigned IDLE_PCT = 27;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned DRAIN_CYCLES = 200;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned MAX_REPORTS = 10;

	typedef struct packed {
		logic digit;
		logic last;
	} digit_exp_t;

	typedef enum logic {
		ENC_IDLE,
		ENC_EMIT
	} enc_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	zeck_value_if value_if ();
	zeck_digit_if digit_if ();

	zeckendorf_encoder_unit #(
		.MAX_DIGITS(ENC_MAX_DIGITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.value_ch (value_if),
		.digit_ch (digit_if)
	);

	// encoder state as seen from the ports
	zeck_pkg::value_t enc_rem;
	zeck_pkg::value_t enc_whigh;
	zeck_pkg::value_t enc_wlow;
	logic [6:0]       enc_left;
	enc_phase_t       enc_phase = ENC_IDLE;

	digit_exp_t digit_exp_q[$];
	digit_exp_t digit_want;
	int unsigned fail_count = 0;
	int unsigned digit_count = 0;
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;

	always #1 clk = ~clk;

	function automatic void note_failure(string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%t: %s", $realtime, msg);
	endfunction

	// greedy fibonacci encoding of one accepted value, up to one burst of digits
	function automatic void predict_code(zeck_pkg::value_t v);
		int unsigned top;
		int unsigned n;
		digit_exp_t d;
		if (enc_phase == ENC_IDLE) begin
			if (v == '0) begin
				d.digit = 1'b0;
				d.last = 1'b1;
				digit_exp_q.push_back(d);
				return;
			end
			// climb to the largest weight not above the value
			enc_whigh = 64'd1;
			enc_wlow = 64'd1;
			top = 0;
			while (top + 1 < ENC_MAX_DIGITS &&
					({1'b0, enc_whigh} + {1'b0, enc_wlow}) <= {1'b0, v}) begin
				{enc_wlow, enc_whigh} = {enc_whigh, enc_whigh + enc_wlow};
				top++;
			end
			enc_rem = v;
			enc_left = 7'(top + 1);
			enc_phase = ENC_EMIT;
		end
		// walk down the weights
		n = 0;
		while (enc_phase == ENC_EMIT && n < DIGITS_PER_XFER) begin
			d.digit = (enc_whigh <= enc_rem);
			if (d.digit)
				enc_rem = enc_rem - enc_whigh;
			enc_left = enc_left - 7'd1;
			d.last = (enc_left == 7'd0);
			digit_exp_q.push_back(d);
			n++;
			if (d.last)
				enc_phase = ENC_IDLE;
			else
				{enc_whigh, enc_wlow} = {enc_wlow, enc_whigh - enc_wlow};
		end
	endfunction

	// mostly short values so that most codes stay short
	function automatic zeck_pkg::value_t random_value();
		zeck_pkg::value_t v;
		int unsigned nbits;
		v = {$urandom, $urandom};
		nbits = ($urandom_range(3) == 0) ? 64 : $urandom_range(64);
		if (nbits < 64)
			v = v & ((64'd1 << nbits) - 64'd1);
		return v;
	endfunction

	// one value transfer, with a random gap in front unless no_idle is set
	task automatic send_value(zeck_pkg::value_t v);
		if (!no_idle) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				value_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		value_if.valid <= 1'b1;
		value_if.value <= v;
		do
			@(posedge clk);
		while (!value_if.ready);
		predict_code(v);
	endtask

	// a value plus the continuation transfers that release a long code
	task automatic send_code(zeck_pkg::value_t v);
		send_value(v);
		while (enc_phase == ENC_EMIT)
			send_value(random_value());
	endtask

	task automatic test_directed();
		send_code(64'd0);
		send_code(64'd1);
		send_code(64'd2);
		send_code(64'd3);
		send_code(64'd4);
		send_code(64'd5);
		send_code(64'd7);
		send_code(64'd8);
		send_code(64'd12);
		send_code(64'h5555_5555_5555_5555);
		send_code(64'hAAAA_AAAA_AAAA_AAAA);
		// exactly one full burst, then one digit more than a burst
		send_code(64'd27777890035287);
		send_code(64'd27777890035288);
		// around the top weight that fits in 64 bits
		send_code(64'd12200160415121876737);
		send_code(64'd12200160415121876738);
		// two long codes whose continuation transfers carry 0 and all ones, which are ignored
		send_value(64'hFFFF_FFFF_FFFF_FFFF);
		send_value(64'd0);
		send_value(64'h8000_0000_0000_0000);
		send_value(64'hFFFF_FFFF_FFFF_FFFF);
		send_code(64'd0);
		send_code(64'd1);
	endtask

	task automatic test_random_codes(int unsigned count);
		repeat (count)
			send_code(random_value());
	endtask

	task automatic test_no_idle(int unsigned count);
		no_idle = 1'b1;
		repeat (count)
			send_code(random_value());
		no_idle = 1'b0;
	endtask

	// output held off for a long stretch while values keep coming
	task automatic test_output_hold(int unsigned count);
		no_idle = 1'b1;
		hold_req = 1'b1;
		repeat (count)
			send_code(random_value());
		no_idle = 1'b0;
	endtask

	// digit receiver with random stalls and one long hold-off
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		digit_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				digit_if.ready <= 1'b0;
			end else begin
				digit_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// compare each digit transfer with the oldest expected digit
	always @(posedge clk) begin
		if (digit_if.valid && digit_if.ready) begin
			if (digit_exp_q.size() == 0) begin
				note_failure($sformatf("digit %0d with nothing expected: digit %b last %b",
					digit_count, digit_if.digit, digit_if.last));
			end else begin
				digit_want = digit_exp_q.pop_front();
				if (digit_if.digit !== digit_want.digit || digit_if.last !== digit_want.last)
					note_failure($sformatf(
						"digit %0d mismatch: expected digit %b last %b, got digit %b last %b",
						digit_count, digit_want.digit, digit_want.last,
						digit_if.digit, digit_if.last));
			end
			digit_count++;
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((value_if.valid && value_if.ready) || (digit_if.valid && digit_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		value_if.valid <= 1'b0;
		value_if.value <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_codes(130);
		test_no_idle(25);
		test_output_hold(10);
		value_if.valid <= 1'b0;

		// drain outstanding digits, then let the block settle
		while (digit_exp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (digit_exp_q.size() != 0)
			note_failure($sformatf("%0d digits never arrived", digit_exp_q.size()));

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
